>>> src/qfts_pkg.sv
// ----------------------------------------------------------------------------
// qfts_pkg: shared types and constants of the two-stack queue
// Holds the value type, the mode codes and the empty-queue marker.
// ----------------------------------------------------------------------------
package qfts_pkg;

   typedef logic signed [31:0] value_type;

   typedef logic mode_type;

   localparam mode_type MODE_PUSH = 1'b0;
   localparam mode_type MODE_POP  = 1'b1;

   // Value returned by a pop of an empty queue, by every push, and as the
   // front of an empty queue.
   localparam value_type NEG_ONE = -32'sd1;

endpackage

>>> src/qfts_if.sv
// ----------------------------------------------------------------------------
// qfts_if: channel interfaces of the two-stack queue
// Request channel (push or pop) and response channel, valid/ready style.
// ----------------------------------------------------------------------------
interface qfts_req_if;
   logic                valid;
   logic                ready;
   qfts_pkg::mode_type  mode;
   qfts_pkg::value_type push_value;

   modport source (output valid, output mode, output push_value, input ready);
   modport sink   (input valid, input mode, input push_value, output ready);
endinterface

interface qfts_rsp_if;
   logic                valid;
   logic                ready;
   qfts_pkg::value_type popped_value;
   logic                pop_found_empty;
   logic                push_dropped;
   qfts_pkg::value_type front_value;
   logic                queue_empty;

   modport source (output valid, output popped_value, output pop_found_empty,
                   output push_dropped, output front_value, output queue_empty,
                   input ready);
   modport sink   (input valid, input popped_value, input pop_found_empty,
                   input push_dropped, input front_value, input queue_empty,
                   output ready);
endinterface

>>> src/qfts_ram.sv
// ----------------------------------------------------------------------------
// qfts_ram: generic single-write, single-read synchronous RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module qfts_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> src/queue_from_two_stacks_top.sv
// ----------------------------------------------------------------------------
// queue_from_two_stacks_top: first-in first-out queue built from two stacks
// A push goes onto the input stack; a pop takes from the output stack and
// refills it from the input stack, in reverse order, when it runs dry.
// ----------------------------------------------------------------------------
// Usage:
//   The request channel carries one transaction per operation: mode selects
//   a push of push_value or a pop of the oldest value. Every request yields
//   exactly one response transaction on the response channel, in order.
//   A push onto a full input stack is dropped and flagged; a pop of an empty
//   queue returns -1 and is flagged. Each response also carries the front of
//   the queue after the operation and whether the queue is now empty.
// Sequencing:
//   The block handles one request at a time. A push goes to S_EMIT; a pop
//   served from the output stack goes to S_POP, then to S_POP_RD to read the
//   new top from the output stack memory unless the stack ran dry, then to
//   S_EMIT, where the response is loaded. The next request is accepted in the
//   cycle after the response is loaded. A pop that finds the output stack
//   empty first moves all n entries of the input stack, one per cycle through
//   its read port. Since each value is moved only once, the sustained cost stays low.
// Reset and stalls:
//   Reset empties both stacks at once (only the counts clear; no memory
//   sweep is needed). The response sits in an output register; while the
//   receiver stalls, the next request is still accepted and processed, and
//   it waits for the output register only when its own response is ready.
// ----------------------------------------------------------------------------
module queue_from_two_stacks_top #(
   parameter int STACK_DEPTH = 128
) (
   input  logic       clock,
   input  logic       reset,
   qfts_req_if.sink   req_if,
   qfts_rsp_if.source rsp_if
);

   // Address width indexes an entry; count width also holds the full depth.
   localparam int AW = $clog2(STACK_DEPTH);
   localparam int CW = $clog2(STACK_DEPTH + 1);
   localparam logic [CW-1:0] DEPTH_C = CW'(STACK_DEPTH);

   typedef enum logic [2:0] {
      S_IDLE,
      S_POP,
      S_POP_RD,
      S_XFER,
      S_EMIT
   } state_type;

   // Sequencer state and stack bookkeeping.
   state_type           state_ff, state_in;
   logic [CW-1:0]       in_count_ff, in_count_in;
   logic [CW-1:0]       out_count_ff, out_count_in;
   logic                rd_pend_ff, rd_pend_in;
   // Cached copies: the top of the output stack (valid while it is not
   // empty) and the bottom of the input stack (valid while it is not empty).
   qfts_pkg::value_type out_top_ff, out_top_in;
   qfts_pkg::value_type in_bottom_ff, in_bottom_in;

   // Result being built for the current request.
   qfts_pkg::value_type res_popped_ff, res_popped_in;
   logic                res_found_empty_ff, res_found_empty_in;
   logic                res_dropped_ff, res_dropped_in;
   qfts_pkg::value_type res_front_ff, res_front_in;
   logic                res_empty_ff, res_empty_in;

   // Output register of the response channel.
   logic                rsp_valid_ff, rsp_valid_in;
   qfts_pkg::value_type rsp_popped_ff, rsp_popped_in;
   logic                rsp_found_empty_ff, rsp_found_empty_in;
   logic                rsp_dropped_ff, rsp_dropped_in;
   qfts_pkg::value_type rsp_front_ff, rsp_front_in;
   logic                rsp_empty_ff, rsp_empty_in;

   // Memory ports.
   logic                in_we;
   logic [AW-1:0]       in_waddr;
   qfts_pkg::value_type in_wdata;
   logic [AW-1:0]       in_raddr;
   qfts_pkg::value_type in_rdata;
   logic                out_we;
   logic [AW-1:0]       out_waddr;
   qfts_pkg::value_type out_wdata;
   logic [AW-1:0]       out_raddr;
   qfts_pkg::value_type out_rdata;

   qfts_ram #(
      .WIDTH (32),
      .DEPTH (STACK_DEPTH)
   ) u_in_stack (
      .clock   (clock),
      .wr_en   (in_we),
      .wr_addr (in_waddr),
      .wr_data (in_wdata),
      .rd_addr (in_raddr),
      .rd_data (in_rdata)
   );

   qfts_ram #(
      .WIDTH (32),
      .DEPTH (STACK_DEPTH)
   ) u_out_stack (
      .clock   (clock),
      .wr_en   (out_we),
      .wr_addr (out_waddr),
      .wr_data (out_wdata),
      .rd_addr (out_raddr),
      .rd_data (out_rdata)
   );

   assign req_if.ready           = (state_ff == S_IDLE);
   assign rsp_if.valid           = rsp_valid_ff;
   assign rsp_if.popped_value    = rsp_popped_ff;
   assign rsp_if.pop_found_empty = rsp_found_empty_ff;
   assign rsp_if.push_dropped    = rsp_dropped_ff;
   assign rsp_if.front_value     = rsp_front_ff;
   assign rsp_if.queue_empty     = rsp_empty_ff;

   always_comb begin
      state_in           = state_ff;
      in_count_in        = in_count_ff;
      out_count_in       = out_count_ff;
      rd_pend_in         = rd_pend_ff;
      out_top_in         = out_top_ff;
      in_bottom_in       = in_bottom_ff;
      res_popped_in      = res_popped_ff;
      res_found_empty_in = res_found_empty_ff;
      res_dropped_in     = res_dropped_ff;
      res_front_in       = res_front_ff;
      res_empty_in       = res_empty_ff;
      rsp_popped_in      = rsp_popped_ff;
      rsp_found_empty_in = rsp_found_empty_ff;
      rsp_dropped_in     = rsp_dropped_ff;
      rsp_front_in       = rsp_front_ff;
      rsp_empty_in       = rsp_empty_ff;

      // A taken response frees the output register.
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;

      // The input stack's read port always points at its current top, and
      // the output stack's at the entry below its current top.
      in_we     = 1'b0;
      in_waddr  = in_count_ff[AW-1:0];
      in_wdata  = req_if.push_value;
      in_raddr  = AW'(in_count_ff - CW'(1));
      out_we    = 1'b0;
      out_waddr = out_count_ff[AW-1:0];
      out_wdata = in_rdata;
      out_raddr = AW'(out_count_ff - CW'(2));

      unique case (state_ff)
         S_IDLE: begin
            if (req_if.valid) begin
               if (req_if.mode == qfts_pkg::MODE_PUSH) begin
                  res_popped_in      = qfts_pkg::NEG_ONE;
                  res_found_empty_in = 1'b0;
                  res_empty_in       = 1'b0;
                  if (in_count_ff == DEPTH_C) begin
                     res_dropped_in = 1'b1;
                  end else begin
                     res_dropped_in = 1'b0;
                     in_we          = 1'b1;
                     in_count_in    = in_count_ff + CW'(1);
                     if (in_count_ff == '0) begin
                        in_bottom_in = req_if.push_value;
                     end
                  end
                  // The front is the output stack's top if it has one,
                  // otherwise the bottom of the input stack.
                  if (out_count_ff != '0) begin
                     res_front_in = out_top_ff;
                  end else if (in_count_ff == '0) begin
                     res_front_in = req_if.push_value;
                  end else begin
                     res_front_in = in_bottom_ff;
                  end
                  state_in = S_EMIT;
               end else begin
                  state_in = S_POP;
               end
            end
         end

         S_POP: begin
            res_dropped_in = 1'b0;
            if (out_count_ff != '0) begin
               res_popped_in      = out_top_ff;
               res_found_empty_in = 1'b0;
               out_count_in       = out_count_ff - CW'(1);
               if (out_count_ff == CW'(1)) begin
                  // Output stack drained: the front falls back to the
                  // input stack, if it holds anything.
                  res_front_in = (in_count_ff != '0) ? in_bottom_ff : qfts_pkg::NEG_ONE;
                  res_empty_in = (in_count_ff == '0);
                  state_in     = S_EMIT;
               end else begin
                  // The new top is being read from the output stack memory.
                  state_in = S_POP_RD;
               end
            end else if (in_count_ff == '0) begin
               res_popped_in      = qfts_pkg::NEG_ONE;
               res_found_empty_in = 1'b1;
               res_front_in       = qfts_pkg::NEG_ONE;
               res_empty_in       = 1'b1;
               state_in           = S_EMIT;
            end else begin
               rd_pend_in = 1'b0;
               state_in   = S_XFER;
            end
         end

         S_POP_RD: begin
            out_top_in   = out_rdata;
            res_front_in = out_rdata;
            res_empty_in = 1'b0;
            state_in     = S_EMIT;
         end

         S_XFER: begin
            // Streamed move: each cycle reads the input stack's top and
            // writes the value read in the previous cycle onto the output
            // stack. The last value written becomes the output stack's top.
            if (rd_pend_ff) begin
               out_we       = 1'b1;
               out_count_in = out_count_ff + CW'(1);
               out_top_in   = in_rdata;
            end
            if (in_count_ff != '0) begin
               in_count_in = in_count_ff - CW'(1);
               rd_pend_in  = 1'b1;
            end else begin
               rd_pend_in = 1'b0;
               state_in   = S_POP;
            end
         end

         S_EMIT: begin
            if (!rsp_valid_ff || rsp_if.ready) begin
               rsp_valid_in       = 1'b1;
               rsp_popped_in      = res_popped_ff;
               rsp_found_empty_in = res_found_empty_ff;
               rsp_dropped_in     = res_dropped_ff;
               rsp_front_in       = res_front_ff;
               rsp_empty_in       = res_empty_ff;
               state_in           = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         in_count_ff  <= '0;
         out_count_ff <= '0;
         rd_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         in_count_ff  <= in_count_in;
         out_count_ff <= out_count_in;
         rd_pend_ff   <= rd_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      out_top_ff         <= out_top_in;
      in_bottom_ff       <= in_bottom_in;
      res_popped_ff      <= res_popped_in;
      res_found_empty_ff <= res_found_empty_in;
      res_dropped_ff     <= res_dropped_in;
      res_front_ff       <= res_front_in;
      res_empty_ff       <= res_empty_in;
      rsp_popped_ff      <= rsp_popped_in;
      rsp_found_empty_ff <= rsp_found_empty_in;
      rsp_dropped_ff     <= rsp_dropped_in;
      rsp_front_ff       <= rsp_front_in;
      rsp_empty_ff       <= rsp_empty_in;
   end

endmodule
